[rtl/sfr_pkg.sv]
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 4;
  localparam int MAX_SUBST   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LEN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_BYTES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SUBST_LEN     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SUBST_BYTES   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SUBST = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // Source of the byte loaded into the output register
  typedef enum logic [2:0] {
    EM_NONE,
    EM_PASS,
    EM_MARK,
    EM_FLUSH,
    EM_SUBST
  } emit_sel_t;

  typedef struct packed {
    logic      step;
    emit_sel_t emit;
    logic      eot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic match;
    logic slen_zero;
    logic rest_zero;
    logic fill_one;
    logic cnt_one;
    logic out_valid;
  } dp_status_t;

  // Zero counts as one; clamp at the window depth
  function automatic logic [LEN_W-1:0] eff_plen(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] p;
    p = v;
    if (p == '0) p = LEN_W'(1);
    if (p > LEN_W'(MAX_PATTERN)) p = LEN_W'(MAX_PATTERN);
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] eff_slen(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] s;
    s = v;
    if (s > LEN_W'(MAX_SUBST)) s = LEN_W'(MAX_SUBST);
    return s;
  endfunction

endpackage

[rtl/sfr_ctrl.sv]
module sfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  input  logic                out_tready,
  input  sfr_pkg::dp_status_t st,
  output sfr_pkg::ctrl_cmd_t  cmd
);

  sfr_pkg::state_t state_r, state_nxt;
  logic            tail_last_r, tail_last_nxt;
  logic            out_free;
  logic            accept;

  always_comb begin
    out_free      = !st.out_valid || out_tready;
    in_tready     = (state_r == sfr_pkg::ST_IDLE) && out_free;
    accept        = in_tvalid && in_tready;
    state_nxt     = state_r;
    tail_last_nxt = tail_last_r;
    cmd.step      = accept;
    cmd.emit      = sfr_pkg::EM_NONE;
    cmd.eot       = 1'b0;
    case (state_r)
      sfr_pkg::ST_IDLE: begin
        if (accept) begin
          if (st.full && st.match) begin
            if (!st.slen_zero) begin
              tail_last_nxt = in_tlast;
              state_nxt     = sfr_pkg::ST_SUBST;
            end else if (in_tlast) begin
              cmd.emit = sfr_pkg::EM_MARK;
              cmd.eot  = 1'b1;
            end
          end else if (st.full) begin
            cmd.emit = sfr_pkg::EM_PASS;
            cmd.eot  = in_tlast && st.rest_zero;
            if (in_tlast && !st.rest_zero) state_nxt = sfr_pkg::ST_FLUSH;
          end else if (in_tlast) begin
            state_nxt = sfr_pkg::ST_FLUSH;
          end
        end
      end
      sfr_pkg::ST_SUBST: begin
        if (out_free) begin
          cmd.emit = sfr_pkg::EM_SUBST;
          cmd.eot  = st.cnt_one && tail_last_r;
          if (st.cnt_one) state_nxt = sfr_pkg::ST_IDLE;
        end
      end
      sfr_pkg::ST_FLUSH: begin
        if (out_free) begin
          cmd.emit = sfr_pkg::EM_FLUSH;
          cmd.eot  = st.fill_one;
          if (st.fill_one) state_nxt = sfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfr_pkg::ST_IDLE;
      tail_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_last_r <= tail_last_nxt;
    end
  end

endmodule

[rtl/sfr_dp.sv]
module sfr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [7:0]                          in_byte,
  input  logic                                out_tready,
  input  sfr_pkg::ctrl_cmd_t                  cmd,
  output sfr_pkg::dp_status_t                 st,
  output logic                                out_valid,
  output logic [7:0]                          out_byte,
  output logic                                out_byte_valid,
  output logic                                out_eot
);

  localparam int N = sfr_pkg::MAX_PATTERN;
  localparam int LW = sfr_pkg::LEN_W;

  logic [LW-1:0]                    plen_r, plen_nxt;
  logic [LW-1:0]                    slen_r, slen_nxt;
  logic [sfr_pkg::CFG_DATA_W-1:0]   pat_r, pat_nxt;
  logic [sfr_pkg::CFG_DATA_W-1:0]   subst_r, subst_nxt;

  logic [7:0]                       win_r [N];
  logic [7:0]                       win_nxt [N];
  logic [7:0]                       wnext [N];
  logic [LW-1:0]                    fill_r, fill_nxt;
  logic [LW-1:0]                    fill_eff;
  logic [sfr_pkg::CFG_DATA_W-1:0]   sub_r, sub_nxt;
  logic [LW-1:0]                    cnt_r, cnt_nxt;

  logic                             ov_r, ov_nxt;
  logic [7:0]                       ob_r, ob_nxt;
  logic                             obv_r, obv_nxt;
  logic                             oeot_r, oeot_nxt;

  logic                             match;
  logic [LW-1:0]                    new_plen;

  // Window with the incoming byte placed at the fill position
  always_comb begin
    fill_eff = (fill_r >= plen_r) ? '0 : fill_r;
    for (int i = 0; i < N; i++) begin
      wnext[i] = (fill_eff[sfr_pkg::WIN_IDX_W-1:0] == sfr_pkg::WIN_IDX_W'(i)) ?
                 in_byte : win_r[i];
    end
    match = 1'b1;
    for (int i = 0; i < N; i++) begin
      if ((LW'(i) < plen_r) && (wnext[i] != pat_r[8*i +: 8])) match = 1'b0;
    end
  end

  always_comb begin
    st.full      = ((fill_eff + LW'(1)) == plen_r);
    st.match     = match;
    st.slen_zero = (slen_r == '0);
    st.rest_zero = (plen_r == LW'(1));
    st.fill_one  = (fill_r == LW'(1));
    st.cnt_one   = (cnt_r == LW'(1));
    st.out_valid = ov_r;
  end

  always_comb begin
    plen_nxt  = plen_r;
    slen_nxt  = slen_r;
    pat_nxt   = pat_r;
    subst_nxt = subst_r;
    fill_nxt  = fill_r;
    win_nxt   = win_r;
    sub_nxt   = sub_r;
    cnt_nxt   = cnt_r;
    new_plen  = sfr_pkg::eff_plen(cfg_wdata[LW-1:0]);

    if (cfg_we) begin
      case (cfg_addr)
        sfr_pkg::REG_PATTERN_LEN: begin
          plen_nxt = new_plen;
          // Drop held bytes once the window no longer fits under the new length
          if (new_plen <= fill_r) fill_nxt = '0;
        end
        sfr_pkg::REG_PATTERN_BYTES: pat_nxt   = cfg_wdata;
        sfr_pkg::REG_SUBST_LEN:     slen_nxt  = sfr_pkg::eff_slen(cfg_wdata[LW-1:0]);
        sfr_pkg::REG_SUBST_BYTES:   subst_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end

    if (cmd.step) begin
      if (st.full && match) begin
        fill_nxt = '0;
        sub_nxt  = subst_r;
        cnt_nxt  = slen_r;
      end else if (st.full) begin
        for (int i = 0; i < N - 1; i++) win_nxt[i] = wnext[i+1];
        win_nxt[N-1] = wnext[N-1];
        fill_nxt     = plen_r - LW'(1);
      end else begin
        win_nxt  = wnext;
        fill_nxt = fill_eff + LW'(1);
      end
    end

    case (cmd.emit)
      sfr_pkg::EM_FLUSH: begin
        for (int i = 0; i < N - 1; i++) win_nxt[i] = win_r[i+1];
        fill_nxt = fill_r - LW'(1);
      end
      sfr_pkg::EM_SUBST: begin
        sub_nxt = sub_r >> 8;
        cnt_nxt = cnt_r - LW'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    ov_nxt   = ov_r && !out_tready;
    ob_nxt   = ob_r;
    obv_nxt  = obv_r;
    oeot_nxt = oeot_r;
    case (cmd.emit)
      sfr_pkg::EM_PASS: begin
        ov_nxt = 1'b1; ob_nxt = wnext[0]; obv_nxt = 1'b1; oeot_nxt = cmd.eot;
      end
      sfr_pkg::EM_MARK: begin
        ov_nxt = 1'b1; ob_nxt = '0; obv_nxt = 1'b0; oeot_nxt = cmd.eot;
      end
      sfr_pkg::EM_FLUSH: begin
        ov_nxt = 1'b1; ob_nxt = win_r[0]; obv_nxt = 1'b1; oeot_nxt = cmd.eot;
      end
      sfr_pkg::EM_SUBST: begin
        ov_nxt = 1'b1; ob_nxt = sub_r[7:0]; obv_nxt = 1'b1; oeot_nxt = cmd.eot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= LW'(1);
      slen_r  <= '0;
      pat_r   <= '0;
      subst_r <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      plen_r  <= plen_nxt;
      slen_r  <= slen_nxt;
      pat_r   <= pat_nxt;
      subst_r <= subst_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    sub_r  <= sub_nxt;
    ob_r   <= ob_nxt;
    obv_r  <= obv_nxt;
    oeot_r <= oeot_nxt;
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_byte_valid = obv_r;
  assign out_eot        = oeot_r;

endmodule

[rtl/substring_find_replace_top.sv]
// Stream substring find-and-replace. Bytes arrive one per transaction on the
// in_ channel (in_tlast marks the final byte of a text) and leave on the out_
// channel with every non-overlapping match of the configured pattern (1 to 8
// bytes) replaced by the replacement text (0 to 8 bytes). Up to pattern
// length minus one undecided bytes are held in a small window. Rate: a byte
// that completes no match, or that pushes one unmatched byte out, is taken
// as soon as the output register is free, so plain text streams at one byte
// per cycle while out_tready stays high. A match holds the input off while
// the replacement leaves through the single output register one byte a
// cycle while out_tready allows. A last byte sends each held byte in the
// flush. When the last byte leaves nothing to send (it finished a match with
// an empty replacement), a single result with out_tuser low and out_tlast
// high marks the end. Write configuration only while the block is idle; a
// new pattern length no greater than the held byte count drops the window.
module substring_find_replace_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] in_byte
  input  logic                               in_tlast,   // is_last
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] out_byte
  output logic                               out_tuser,  // [0] byte_valid
  output logic                               out_tlast   // end_of_text
);

  sfr_pkg::ctrl_cmd_t  cmd;
  sfr_pkg::dp_status_t st;

  // Sequence the emission of pass, flush, replacement and end-marker results
  sfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // Hold the window, the configuration and the output register
  sfr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_byte        (in_tdata),
    .out_tready     (out_tready),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_tvalid),
    .out_byte       (out_tdata),
    .out_byte_valid (out_tuser),
    .out_eot        (out_tlast)
  );

endmodule

[rtl/sfr_checker.sv]
module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // Stalled result holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // An end marker without data only closes a text
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == 8'd0))
    else $error("marker result without end of text");

  // Input is held off while the output register is full and stalled
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind substring_find_replace_top sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[test/testbench.sv]
module testbench;

  // Cycles to let pass after the last expected result before touching the
  // configuration or ending the run: covers a byte still being absorbed into
  // the window and the longest replacement burst.
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       eot;
  } text_out_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [sfr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;   // [7:0] in_byte
  logic                           in_tlast = 1'b0; // is_last
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;       // [7:0] out_byte
  logic                           out_tuser;       // [0] byte_valid
  logic                           out_tlast;       // end_of_text

  substring_find_replace_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Shadow copy of the block: register file plus the window of held bytes
  logic [3:0]  sh_plen = 4'd1;
  logic [63:0] sh_pattern = '0;
  logic [3:0]  sh_slen = 4'd0;
  logic [63:0] sh_subst = '0;
  logic [7:0]  win [sfr_pkg::MAX_PATTERN];
  int unsigned win_fill = 0;

  // Rewritten text still owed by the block, oldest first
  text_out_t rewritten_q [$];

  int unsigned err_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  bit          quiet = 1'b0;   // suppress idling on both sides

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    #8_000_000;
    $display("TIMEOUT: stream stalled with %0d results outstanding", rewritten_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, a few long ones, none while quiet
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic int unsigned pattern_span();
    if (sh_plen == 4'd0) return 1;
    if (sh_plen > 4'(sfr_pkg::MAX_PATTERN)) return sfr_pkg::MAX_PATTERN;
    return 32'(sh_plen);
  endfunction

  function automatic int unsigned subst_span();
    if (sh_slen > 4'(sfr_pkg::MAX_SUBST)) return sfr_pkg::MAX_SUBST;
    return 32'(sh_slen);
  endfunction

  function automatic void owe_byte(input logic [7:0] b, input logic has_byte);
    text_out_t r;
    r.data = b;
    r.has_byte = has_byte;
    r.eot = 1'b0;
    rewritten_q.push_back(r);
  endfunction

  // Advance the shadow window by one accepted byte and queue what it releases
  function automatic void rewrite_byte(input logic [7:0] b, input logic last);
    int unsigned span;
    int unsigned owed_before;
    bit          hit;
    span = pattern_span();
    owed_before = rewritten_q.size();
    if (win_fill >= span) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill == span) begin
      hit = 1'b1;
      for (int k = 0; k < span; k++)
        if (win[k] != sh_pattern[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        for (int k = 0; k < subst_span(); k++) owe_byte(sh_subst[8*k +: 8], 1'b1);
        win_fill = 0;
      end else begin
        // oldest held byte can no longer start a match: release it
        owe_byte(win[0], 1'b1);
        for (int k = 1; k < span; k++) win[k-1] = win[k];
        win_fill--;
      end
    end
    if (last) begin
      for (int k = 0; k < win_fill; k++) owe_byte(win[k], 1'b1);
      win_fill = 0;
      // nothing left to carry the end mark: a bare marker stands in
      if (rewritten_q.size() == owed_before) owe_byte(8'h00, 1'b0);
      rewritten_q[$].eot = 1'b1;
      texts_sent++;
    end
    bytes_sent++;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    if (err_count < MAX_REPORTS)
      $display("MISMATCH @%0t result %0d: %s expected %0h got %0h",
               $realtime, results_seen, what, want, got);
    err_count++;
  endtask

  // Check every result transaction against the oldest owed result
  always @(posedge clk) begin : result_check
    text_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rewritten_q.size() == 0) begin
        report_mismatch("unexpected result, byte", 8'h00, out_tdata);
      end else begin
        want = rewritten_q.pop_front();
        if (out_tdata !== want.data) report_mismatch("out_byte", want.data, out_tdata);
        if (out_tuser !== want.has_byte)
          report_mismatch("byte_valid", 8'(want.has_byte), 8'(out_tuser));
        if (out_tlast !== want.eot)
          report_mismatch("end_of_text", 8'(want.eot), 8'(out_tlast));
      end
      results_seen++;
    end
  end

  // Receiver pacing: runs of ready broken by stalls
  initial begin : sink_pacing
    int unsigned run;
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      run = $urandom_range(1, 12);
      @(negedge clk) out_tready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  // Offer one byte, optionally after a gap, and hold until the transaction
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rewrite_byte(b, last);
  endtask

  // Drop valid, wait for every owed result, then let the block settle
  task automatic wait_idle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfr_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sfr_pkg::REG_PATTERN_LEN: begin
        sh_plen = val[3:0];
        // pattern no longer than the held bytes: the window is discarded
        if (pattern_span() <= win_fill) win_fill = 0;
      end
      sfr_pkg::REG_PATTERN_BYTES: sh_pattern = val;
      sfr_pkg::REG_SUBST_LEN:     sh_slen = val[3:0];
      sfr_pkg::REG_SUBST_BYTES:   sh_subst = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [3:0] plen, input logic [63:0] pat,
                              input logic [3:0] slen, input logic [63:0] sub);
    wait_idle();
    write_reg(sfr_pkg::REG_PATTERN_LEN, 64'(plen));
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
    write_reg(sfr_pkg::REG_SUBST_LEN, 64'(slen));
    write_reg(sfr_pkg::REG_SUBST_BYTES, sub);
  endtask

  // Reset settings: one-byte pattern 00, empty replacement, so 00 is deleted
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);   // deleted last byte: marker only
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Self-overlapping pattern: scanning resumes past each match
  task automatic test_overlap_scan();
    program_regs(4'd2, 64'h6161, 4'd3, 64'h5A5958);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
  endtask

  // Oversized lengths saturate; a zero pattern length acts as one byte
  task automatic test_extreme_lengths();
    program_regs(4'd15, '1, 4'd15, 64'h0706050403020100);
    for (int k = 0; k < sfr_pkg::MAX_PATTERN; k++)
      send_byte(8'hFF, k == sfr_pkg::MAX_PATTERN - 1);
    program_regs(4'd0, {$urandom, 24'($urandom), 8'h80}, 4'd8, {$urandom, $urandom});
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // Rewrite the pattern length while bytes are held in the window
  task automatic test_window_rewrite();
    program_regs(4'd4, 64'h64636261, 4'd1, 64'h51);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    // hold the sender until the block owes nothing
    wait_idle();
    write_reg(sfr_pkg::REG_PATTERN_LEN, 64'd2);   // not above the two held bytes: drop
    send_byte(8'h63, 1'b1);
    wait_idle();
    write_reg(sfr_pkg::REG_PATTERN_LEN, 64'd4);
    send_byte(8'h61, 1'b0);
    wait_idle();
    write_reg(sfr_pkg::REG_PATTERN_LEN, 64'd6);   // longer than held: keep
    send_byte(8'h62, 1'b1);
  endtask

  // Texts built mostly from pattern pieces, the rest plain noise
  task automatic test_random_texts();
    int unsigned span;
    int unsigned sent;
    int unsigned len;
    int unsigned cut;
    logic [3:0]  plen;
    logic [3:0]  slen;
    logic [63:0] pat;
    logic [7:0]  alpha [2];
    logic [7:0]  text [$];
    for (int phase = 0; phase < 6; phase++) begin
      alpha[0] = 8'($urandom);
      alpha[1] = 8'($urandom);
      case (phase)
        0: begin plen = 4'd1;  slen = 4'($urandom_range(0, 2)); end
        1: begin plen = 4'd8;  slen = 4'd8;  end
        2: begin plen = 4'd0;  slen = 4'd0;  end
        3: begin plen = 4'd15; slen = 4'd15; end
        default: begin
          plen = 4'($urandom_range(0, 15));
          slen = 4'($urandom_range(0, 15));
        end
      endcase
      // small alphabet so patterns repeat and overlap
      for (int k = 0; k < 8; k++)
        pat[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                   : alpha[$urandom_range(0, 1)];
      program_regs(plen, pat, slen, {$urandom, $urandom});
      quiet = (phase == 4);
      span = pattern_span();
      sent = 0;
      while (sent < 32) begin
        text.delete();
        len = $urandom_range(1, 24);
        if ($urandom_range(0, 4) == 0) begin
          while (text.size() < len) text.push_back(8'($urandom));
        end else begin
          while (text.size() < len) begin
            case ($urandom_range(0, 3))
              0: for (int k = 0; k < span; k++) text.push_back(pat[8*k +: 8]);
              1: begin
                cut = $urandom_range(1, span);
                for (int k = 0; k < cut; k++) text.push_back(pat[8*k +: 8]);
              end
              2: text.push_back(alpha[$urandom_range(0, 1)]);
              default: text.push_back(8'($urandom));
            endcase
          end
        end
        for (int k = 0; k < text.size(); k++) send_byte(text[k], k == text.size() - 1);
        sent += text.size();
      end
      quiet = 1'b0;
    end
  endtask

  initial begin : main_seq
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_reset_defaults();
    test_overlap_scan();
    test_extreme_lengths();
    test_window_rewrite();
    test_random_texts();
    wait_idle();
    $display("Covered %0d bytes in %0d texts under %0d register writes,",
             bytes_sent, texts_sent, cfg_writes);
    $display("including deletion, overlap, saturated lengths and window drops; %0d %s",
             results_seen, "results checked.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sfr_pkg.sv
rtl/sfr_ctrl.sv
rtl/sfr_dp.sv
rtl/substring_find_replace_top.sv
rtl/sfr_checker.sv
test/testbench.sv
